// ===== rtl/fdss_pkg.sv =====
// Shared types, constants and the segment decode for the four-digit
// seven-segment scanner. No dependencies.
package fdss_pkg;

  // Request kinds carried in tuser
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_BLINK = 2'd2
  } cmd_e;

  localparam logic [6:0] BLINK_HALF   = 7'd33;
  localparam logic [6:0] BLINK_PERIOD = 7'd66;
  localparam logic [7:0] VALUE_MAX    = 8'd99;
  localparam logic [7:0] POINT_MASK   = 8'h80;

  // Decoded request handed from the input stage to the display state
  typedef struct packed {
    logic       valid;
    cmd_e       cmd;
    logic [3:0] left_tens;
    logic [3:0] left_ones;
    logic [3:0] right_tens;
    logic [3:0] right_ones;
  } disp_req_t;

  // Segments a..g in bits 0..6; codes above 9 stay dark
  function automatic logic [7:0] seg_decode(input logic [3:0] digit);
    logic [7:0] pattern;
    case (digit)
      4'd0:    pattern = 8'h3F;
      4'd1:    pattern = 8'h06;
      4'd2:    pattern = 8'h5B;
      4'd3:    pattern = 8'h4F;
      4'd4:    pattern = 8'h66;
      4'd5:    pattern = 8'h6D;
      4'd6:    pattern = 8'h7D;
      4'd7:    pattern = 8'h07;
      4'd8:    pattern = 8'h7F;
      4'd9:    pattern = 8'h6F;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

// ===== rtl/fdss_split.sv =====
// Clamps one 8-bit value to 99 and splits it into tens and ones digits.
// Uses fdss_pkg for the clamp limit.
module fdss_split (
  input  logic [7:0] value_i,
  output logic [3:0] tens_o,
  output logic [3:0] ones_o
);

  logic [6:0]  sat;
  logic [14:0] prod;
  logic [6:0]  tens_x10;

  // After the clamp the value fits in 7 bits
  assign sat = (value_i > fdss_pkg::VALUE_MAX) ? fdss_pkg::VALUE_MAX[6:0] : value_i[6:0];

  // v / 10 == (v * 205) >> 11 for every v up to 99
  assign prod     = {8'd0, sat} * 15'd205;
  assign tens_o   = prod[14:11];
  assign tens_x10 = {tens_o, 3'd0} + {2'd0, tens_o, 1'b0};
  assign ones_o   = 4'(sat - tens_x10);

endmodule

// ===== rtl/fdss_disp.sv =====
// Display state: digit store, scan phase, blink counter and the registered
// segment and enable lines. Uses fdss_pkg for request type and decode.
module fdss_disp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdss_pkg::disp_req_t  req_i,
  output logic [7:0]           segment_lines_o,
  output logic [3:0]           digit_enable_n_o
);

  logic [3:0] digit_q [4];
  logic [1:0] scan_phase_q, scan_phase_d;
  logic [6:0] blink_count_q, blink_count_d;
  logic       point_on_q, point_on_d;
  logic [7:0] segment_q, segment_d;
  logic [3:0] enable_q, enable_d;
  logic [6:0] blink_inc;
  logic [1:0] slot;
  logic       do_load;

  assign slot      = ~scan_phase_q;
  assign blink_inc = blink_count_q + 7'd1;
  assign do_load   = req_i.valid && (req_i.cmd == fdss_pkg::CMD_LOAD);

  always_comb begin
    scan_phase_d  = scan_phase_q;
    blink_count_d = blink_count_q;
    point_on_d    = point_on_q;
    segment_d     = segment_q;
    enable_d      = enable_q;
    if (req_i.valid) begin
      case (req_i.cmd)
        fdss_pkg::CMD_SCAN: begin
          segment_d = fdss_pkg::seg_decode(digit_q[slot]);
          if (slot == 2'd1 && point_on_q) begin
            segment_d = segment_d | fdss_pkg::POINT_MASK;
          end
          enable_d     = ~(4'd1 << slot);
          scan_phase_d = scan_phase_q + 2'd1;
        end
        fdss_pkg::CMD_BLINK: begin
          blink_count_d = blink_inc;
          if (blink_inc == fdss_pkg::BLINK_HALF) begin
            point_on_d = 1'b0;
          end
          if (blink_inc == fdss_pkg::BLINK_PERIOD) begin
            point_on_d    = 1'b1;
            blink_count_d = 7'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_phase_q  <= 2'd0;
      blink_count_q <= 7'd0;
      point_on_q    <= 1'b1;
      segment_q     <= 8'd0;
      enable_q      <= 4'hF;
      digit_q[0]    <= 4'd0;
      digit_q[1]    <= 4'd0;
      digit_q[2]    <= 4'd0;
      digit_q[3]    <= 4'd0;
    end else begin
      scan_phase_q  <= scan_phase_d;
      blink_count_q <= blink_count_d;
      point_on_q    <= point_on_d;
      segment_q     <= segment_d;
      enable_q      <= enable_d;
      if (do_load) begin
        digit_q[0] <= req_i.left_tens;
        digit_q[1] <= req_i.left_ones;
        digit_q[2] <= req_i.right_tens;
        digit_q[3] <= req_i.right_ones;
      end
    end
  end

  assign segment_lines_o  = segment_q;
  assign digit_enable_n_o = enable_q;

endmodule

// ===== rtl/four_digit_seven_segment_scanner_core.sv =====
// Four-digit seven-segment scanner, top level.
// A request passes the input register and then the line register on its way to a response.
// Throughput: one request per cycle while the output is not stalled; the display state update is one short step.
// Reset: asynchronous, active low; digits clear to 0, point lit, all digits off.
// Depends on fdss_pkg, fdss_split and fdss_disp.
module four_digit_seven_segment_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] left_value, [15:8] right_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] segment_lines, [11:8] digit_enable_n, rest 0
);

  logic                in_valid_q;
  fdss_pkg::cmd_e      cmd_q;
  logic [7:0]          left_q;
  logic [7:0]          right_q;
  logic                out_valid_q;
  logic                advance;
  fdss_pkg::disp_req_t req;
  logic [7:0]          segment_lines;
  logic [3:0]          digit_enable_n;

  // Move the held request on when the output slot is free or being taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q   <= fdss_pkg::cmd_e'(s_axis_tuser);
      left_q  <= s_axis_tdata[7:0];
      right_q <= s_axis_tdata[15:8];
    end
  end

  fdss_split u_split_left (
    .value_i (left_q),
    .tens_o  (req.left_tens),
    .ones_o  (req.left_ones)
  );

  fdss_split u_split_right (
    .value_i (right_q),
    .tens_o  (req.right_tens),
    .ones_o  (req.right_ones)
  );

  assign req.valid = in_valid_q && advance;
  assign req.cmd   = cmd_q;

  fdss_disp u_disp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .segment_lines_o  (segment_lines),
    .digit_enable_n_o (digit_enable_n)
  );

  // Lines only change when a request advances, so they hold while stalled
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, digit_enable_n, segment_lines};

`ifndef SYNTHESIS
  // At most one digit is ever lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_enable_n == 4'hF) || $onehot(~digit_enable_n))
    else $error("more than one digit enabled");

  // The decimal point only shows on the ones digit of the left pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    segment_lines[7] |-> (digit_enable_n == 4'b1101))
    else $error("decimal point on wrong digit");

  // A held request is not dropped while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("held request lost");

  // A stalled response keeps its lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(segment_lines) && $stable(digit_enable_n))
    else $error("lines changed under stall");
`endif

endmodule

// ===== sim/four_digit_seven_segment_scanner_core_tb.sv =====
// Self-checking testbench for four_digit_seven_segment_scanner_core.
// Streams load, scan and blink requests, predicts the display lines and compares
// each response with the prediction. Depends on fdss_pkg and the scanner RTL.
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner_core_tb;

  localparam int CLK_HALF_NS      = 4;
  localparam int RESET_CYCLES     = 11;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 400;

  // tuser code that the block must ignore
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] left_value;
    logic [7:0] right_value;
  } disp_item_t;

  typedef struct packed {
    logic [7:0] segment_lines;
    logic [3:0] digit_enable_n;
  } lines_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] left_value, [15:8] right_value
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] segment_lines, [11:8] digit_enable_n

  four_digit_seven_segment_scanner_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  disp_item_t request_q[$];
  lines_t     lines_q[$];
  disp_item_t cur_request;
  bit         request_taken;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         err_cnt;
  int         stall_cnt;

  // Display state as the block should hold it
  logic [1:0] scan_phase;
  logic [6:0] blink_cnt;
  logic       point_lit;
  logic [3:0] digit_store [4];
  logic [7:0] segment_now;
  logic [3:0] enable_now;

  initial clk_i = 1'b0;
  always #(CLK_HALF_NS) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  task automatic predict_lines(input disp_item_t it);
    logic [7:0] lv;
    logic [7:0] rv;
    int         slot;
    lv = (it.left_value > fdss_pkg::VALUE_MAX) ? fdss_pkg::VALUE_MAX : it.left_value;
    rv = (it.right_value > fdss_pkg::VALUE_MAX) ? fdss_pkg::VALUE_MAX : it.right_value;
    case (it.cmd)
      fdss_pkg::CMD_LOAD: begin
        digit_store[0] = 4'(lv / 10);
        digit_store[1] = 4'(lv % 10);
        digit_store[2] = 4'(rv / 10);
        digit_store[3] = 4'(rv % 10);
      end
      fdss_pkg::CMD_SCAN: begin
        // scan runs right to left: ones of right first, tens of left last
        slot = 3 - int'(scan_phase);
        segment_now = digit_glyph(digit_store[slot]);
        if (slot == 1 && point_lit) segment_now = segment_now | fdss_pkg::POINT_MASK;
        enable_now = 4'hF & ~(4'b0001 << slot);
        scan_phase = scan_phase + 2'd1;
      end
      fdss_pkg::CMD_BLINK: begin
        // increment first, then compare
        blink_cnt = blink_cnt + 7'd1;
        if (blink_cnt == fdss_pkg::BLINK_HALF) point_lit = 1'b0;
        if (blink_cnt == fdss_pkg::BLINK_PERIOD) begin
          point_lit = 1'b1;
          blink_cnt = '0;
        end
      end
      default: ;
    endcase
    lines_q.push_back('{segment_lines: segment_now, digit_enable_n: enable_now});
  endtask

  function automatic disp_item_t make_item(input logic [1:0] cmd, input int lv, input int rv);
    disp_item_t it;
    it.cmd         = cmd;
    it.left_value  = 8'(lv);
    it.right_value = 8'(rv);
    return it;
  endfunction

  function automatic logic [7:0] random_value();
    logic [7:0] v;
    case ($urandom_range(3))
      0, 1:    v = 8'($urandom_range(255));
      2:       v = 8'($urandom_range(99));
      default: begin
        case ($urandom_range(5))
          0:       v = 8'd0;
          1:       v = 8'd9;
          2:       v = 8'd10;
          3:       v = 8'd99;
          4:       v = 8'd100;
          default: v = 8'd255;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic disp_item_t random_item();
    disp_item_t it;
    int         r;
    r = $urandom_range(99);
    if (r < 25)      it.cmd = fdss_pkg::CMD_LOAD;
    else if (r < 63) it.cmd = fdss_pkg::CMD_SCAN;
    else if (r < 95) it.cmd = fdss_pkg::CMD_BLINK;
    else             it.cmd = CMD_NONE;
    it.left_value  = random_value();
    it.right_value = random_value();
    return it;
  endfunction

  // Hold off new requests until every response is back
  task automatic wait_drained();
    while (request_q.size() != 0 || s_axis_tvalid || lines_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: present requests from request_q, idling at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!s_axis_tvalid || request_taken) begin
        request_taken = 1'b0;
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_request = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_request.cmd;
          s_axis_tdata  <= {cur_request.right_value, cur_request.left_value};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Predict on each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_lines(cur_request);
      request_taken = 1'b1;
    end
  end

  // Monitor: compare each response with the oldest prediction
  always @(posedge clk_i) begin
    lines_t exp_lines;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lines_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response tdata=%h", m_axis_tdata));
      end else begin
        exp_lines = lines_q.pop_front();
        if (m_axis_tdata[7:0] !== exp_lines.segment_lines)
          report_mismatch($sformatf("segment_lines got %h want %h",
                                    m_axis_tdata[7:0], exp_lines.segment_lines));
        if (m_axis_tdata[11:8] !== exp_lines.digit_enable_n)
          report_mismatch($sformatf("digit_enable_n got %h want %h",
                                    m_axis_tdata[11:8], exp_lines.digit_enable_n));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("[four_digit_seven_segment_scanner_core] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    request_taken = 1'b0;
    err_cnt       = 0;
    stall_cnt     = 0;
    scan_phase    = '0;
    blink_cnt     = '0;
    point_lit     = 1'b1;
    segment_now   = '0;
    enable_now    = 4'hF;
    for (int i = 0; i < 4; i++) digit_store[i] = '0;
    send_idle_pct = 15;
    recv_idle_pct = 82;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset lines, clamping, digit split edges, full scans, ignored code
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 255, 255));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_LOAD, 99, 99));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_LOAD, 100, 255));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_LOAD, 9, 10));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(CMD_NONE, 255, 255));
    request_q.push_back(make_item(fdss_pkg::CMD_LOAD, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_BLINK, 170, 85));
    request_q.push_back(make_item(fdss_pkg::CMD_LOAD, 85, 170));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    request_q.push_back(make_item(CMD_NONE, 0, 0));
    request_q.push_back(make_item(fdss_pkg::CMD_SCAN, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 15; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) request_q.push_back(random_item());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lines_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", lines_q.size()));
    if (err_cnt == 0) begin
      $display("[four_digit_seven_segment_scanner_core] OK");
    end else begin
      $display("[four_digit_seven_segment_scanner_core] ERROR");
    end
    $finish;
  end

endmodule
